// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

    localparam int MAX_FEATURES = 1024;
    localparam int WEIGHT_BITS  = 24;
    localparam int ADDR_W       = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int POS_W        = $clog2(MAX_FEATURES + 1);
    localparam int FEAT_W       = 8;
    localparam int DELTA_W      = FEAT_W + 2;
    localparam int PROD_W       = WEIGHT_BITS + FEAT_W + 1;
    localparam int ACC_W        = 48;
    localparam int STREAK_W     = 16;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_SCORE,
        ST_DECIDE,
        ST_WALK,
        ST_DRAIN
    } ptc_state_t;

    typedef struct packed {
        logic in_ready;
        logic clear;
        logic mul;
        logic score;
        logic out_load;
        logic walk_rd;
        logic pos_clear;
    } ptc_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic last;
        logic clear_last;
        logic out_busy;
        logic miss;
        logic walk_last;
        logic pos_zero;
    } ptc_status_t;

    function automatic logic signed [ACC_W-1:0] sat_acc(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic [ACC_W:0] s;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1])
            return s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        return s[ACC_W-1:0];
    endfunction

    function automatic logic signed [WEIGHT_BITS-1:0] sat_w(
        input logic signed [WEIGHT_BITS-1:0] a,
        input logic signed [DELTA_W-1:0]     d
    );
        logic [WEIGHT_BITS:0] s;
        logic [WEIGHT_BITS:0] dx;
        dx = (WEIGHT_BITS + 1)'(d);
        s  = {a[WEIGHT_BITS-1], a} + dx;
        if (s[WEIGHT_BITS] != s[WEIGHT_BITS-1])
            return s[WEIGHT_BITS] ? {1'b1, {(WEIGHT_BITS-1){1'b0}}}
                                  : {1'b0, {(WEIGHT_BITS-1){1'b1}}};
        return s[WEIGHT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/ptc_if.sv =====
interface ptc_in_if;
    logic                         valid;
    logic                         ready;
    logic [ptc_pkg::FEAT_W-1:0]   feature;
    logic                         label;
    logic                         last_feature;

    modport source (output valid, feature, label, last_feature, input ready);
    modport sink   (input valid, feature, label, last_feature, output ready);
endinterface

interface ptc_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptc_pkg::ACC_W-1:0]   score;
    logic                               correct;
    logic                               weights_updated;
    logic [ptc_pkg::STREAK_W-1:0]       streak;
    logic                               converged;

    modport source (output valid, score, correct, weights_updated, streak, converged,
                    input ready);
    modport sink   (input valid, score, correct, weights_updated, streak, converged,
                    output ready);
endinterface

// ===== rtl/ptc_ctrl.sv =====
module ptc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptc_pkg::ptc_status_t status,
    output ptc_pkg::ptc_cmd_t    cmd
);

    ptc_pkg::ptc_state_t state_reg;
    ptc_pkg::ptc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ptc_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ptc_pkg::ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = ptc_pkg::ST_IDLE;
            end
            ptc_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (status.in_valid)
                    state_next = ptc_pkg::ST_MUL;
            end
            ptc_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = status.last ? ptc_pkg::ST_ACC : ptc_pkg::ST_IDLE;
            end
            ptc_pkg::ST_ACC:
            begin
                // accumulator takes the last product this cycle
                state_next = ptc_pkg::ST_SCORE;
            end
            ptc_pkg::ST_SCORE:
            begin
                cmd.score  = 1'b1;
                state_next = ptc_pkg::ST_DECIDE;
            end
            ptc_pkg::ST_DECIDE:
            begin
                if (!status.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    if (status.miss && !status.pos_zero)
                        state_next = ptc_pkg::ST_WALK;
                    else
                    begin
                        cmd.pos_clear = 1'b1;
                        state_next    = ptc_pkg::ST_IDLE;
                    end
                end
            end
            ptc_pkg::ST_WALK:
            begin
                cmd.walk_rd = 1'b1;
                if (status.walk_last)
                    state_next = ptc_pkg::ST_DRAIN;
            end
            ptc_pkg::ST_DRAIN:
            begin
                // final write-back lands this cycle
                cmd.pos_clear = 1'b1;
                state_next    = ptc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = ptc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

// ===== rtl/ptc_datapath.sv =====
module ptc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    ptc_in_if.sink                             in_ch,
    ptc_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  ptc_pkg::ptc_cmd_t                  cmd,
    output ptc_pkg::ptc_status_t               status
);

    localparam int AW = ptc_pkg::ADDR_W;
    localparam int PW = ptc_pkg::POS_W;
    localparam int WB = ptc_pkg::WEIGHT_BITS;
    localparam int AC = ptc_pkg::ACC_W;
    localparam int SW = ptc_pkg::STREAK_W;

    logic signed [WB-1:0]                 wmem [ptc_pkg::MAX_FEATURES];
    logic [ptc_pkg::FEAT_W-1:0]           fmem [ptc_pkg::MAX_FEATURES];

    logic                                 learn_reg;
    logic [SW-1:0]                        tcount_reg;
    logic [PW-1:0]                        pos_reg;
    logic [AW-1:0]                        walk_cnt_reg;
    logic signed [AC-1:0]                 acc_reg;
    logic signed [WB-1:0]                 bias_reg;
    logic [SW-1:0]                        streak_reg;
    logic                                 done_reg;
    logic                                 pend_reg;
    logic                                 wb_valid_reg;
    logic                                 out_valid_reg;

    logic [ptc_pkg::FEAT_W-1:0]           feat_reg;
    logic                                 label_reg;
    logic                                 last_reg;
    logic                                 in_range_reg;
    logic signed [WB-1:0]                 w_rdata_reg;
    logic [ptc_pkg::FEAT_W-1:0]           f_rdata_reg;
    logic signed [ptc_pkg::PROD_W-1:0]    prod_reg;
    logic signed [AC-1:0]                 score_reg;
    logic [AW-1:0]                        wb_addr_reg;
    logic signed [AC-1:0]                 out_score_reg;
    logic                                 out_correct_reg;
    logic                                 out_updated_reg;
    logic [SW-1:0]                        out_streak_reg;
    logic                                 out_done_reg;

    logic                                 load;
    logic                                 in_range;
    logic [AW-1:0]                        w_raddr;
    logic signed [ptc_pkg::PROD_W-1:0]    prod_next;
    logic signed [ptc_pkg::DELTA_W-1:0]   delta;
    logic                                 score_pos;
    logic                                 score_neg;
    logic                                 correct;
    logic                                 train;
    logic                                 miss;
    logic [SW-1:0]                        streak_next;
    logic                                 done_next;
    logic [AW-1:0]                        walk_cnt_next;

    assign in_ch.ready = cmd.in_ready;
    assign load        = in_ch.valid && cmd.in_ready;
    assign in_range    = pos_reg < PW'(ptc_pkg::MAX_FEATURES);
    assign w_raddr     = cmd.walk_rd ? walk_cnt_reg : pos_reg[AW-1:0];

    // weight times unsigned pixel; features past the store contribute nothing
    assign prod_next = in_range_reg
        ? ptc_pkg::PROD_W'(w_rdata_reg) * ptc_pkg::PROD_W'($signed({1'b0, feat_reg}))
        : '0;

    assign delta = label_reg ? $signed(ptc_pkg::DELTA_W'(f_rdata_reg))
                             : -$signed(ptc_pkg::DELTA_W'(f_rdata_reg));

    // sign test: strict in learn mode, zero counts as a pass when predicting
    assign score_neg = score_reg[AC-1];
    assign score_pos = !score_reg[AC-1] && (score_reg != '0);
    always_comb
    begin
        if (learn_reg)
            correct = label_reg ? score_pos : score_neg;
        else
            correct = label_reg ? !score_neg : (score_neg || (score_reg == '0));
    end

    assign train = learn_reg && !done_reg;
    assign miss  = train && !correct;

    always_comb
    begin
        streak_next = streak_reg;
        done_next   = done_reg;
        if (train)
        begin
            if (!correct)
                streak_next = '0;
            else if (streak_reg != '1)
                streak_next = streak_reg + SW'(1);
            done_next = streak_next >= tcount_reg;
        end
    end

    always_comb
    begin
        walk_cnt_next = walk_cnt_reg;
        if (cmd.clear)
            walk_cnt_next = status.clear_last ? '0 : walk_cnt_reg + AW'(1);
        else if (cmd.walk_rd)
            walk_cnt_next = walk_cnt_reg + AW'(1);
        else if (cmd.pos_clear)
            walk_cnt_next = '0;
    end

    always_comb
    begin
        status.in_valid   = in_ch.valid;
        status.last       = last_reg;
        status.clear_last = walk_cnt_reg == AW'(ptc_pkg::MAX_FEATURES - 1);
        status.out_busy   = out_valid_reg && !out_ch.ready;
        status.miss       = miss;
        status.walk_last  = {1'b0, walk_cnt_reg} == (pos_reg - PW'(1));
        status.pos_zero   = pos_reg == '0;
    end

    // memories
    always_ff @(posedge clk)
    begin
        w_rdata_reg <= wmem[w_raddr];
        f_rdata_reg <= fmem[walk_cnt_reg];
        if (load && in_range)
            fmem[pos_reg[AW-1:0]] <= in_ch.feature;
        if (cmd.clear)
            wmem[walk_cnt_reg] <= '0;
        else if (wb_valid_reg)
            wmem[wb_addr_reg] <= ptc_pkg::sat_w(w_rdata_reg, delta);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            feat_reg     <= in_ch.feature;
            label_reg    <= in_ch.label;
            last_reg     <= in_ch.last_feature;
            in_range_reg <= in_range;
        end
        if (cmd.mul)
            prod_reg <= prod_next;
        if (cmd.score)
            score_reg <= ptc_pkg::sat_acc(acc_reg, AC'(bias_reg));
        wb_addr_reg <= walk_cnt_reg;
        if (cmd.out_load)
        begin
            out_score_reg   <= score_reg;
            out_correct_reg <= correct;
            out_updated_reg <= miss;
            out_streak_reg  <= streak_next;
            out_done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            learn_reg     <= 1'b1;
            tcount_reg    <= SW'(1);
            pos_reg       <= '0;
            walk_cnt_reg  <= '0;
            acc_reg       <= '0;
            bias_reg      <= '0;
            streak_reg    <= '0;
            done_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            wb_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    ptc_pkg::CFG_LEARN_ENABLE: learn_reg  <= cfg_data[0];
                    ptc_pkg::CFG_TRAIN_COUNT:  tcount_reg <= cfg_data[SW-1:0];
                    default: ;
                endcase
            end

            if (cmd.pos_clear)
                pos_reg <= '0;
            else if (load && in_range)
                pos_reg <= pos_reg + PW'(1);

            walk_cnt_reg <= walk_cnt_next;
            wb_valid_reg <= cmd.walk_rd;

            // product is folded in the cycle after the multiply
            pend_reg <= cmd.mul;
            if (cmd.score)
                acc_reg <= '0;
            else if (pend_reg)
                acc_reg <= ptc_pkg::sat_acc(acc_reg, AC'(prod_reg));

            if (cmd.out_load)
            begin
                streak_reg <= streak_next;
                done_reg   <= done_next;
                if (miss)
                    bias_reg <= ptc_pkg::sat_w(bias_reg,
                        label_reg ? ptc_pkg::DELTA_W'(1) : -ptc_pkg::DELTA_W'(1));
            end

            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.score           = out_score_reg;
    assign out_ch.correct         = out_correct_reg;
    assign out_ch.weights_updated = out_updated_reg;
    assign out_ch.streak          = out_streak_reg;
    assign out_ch.converged       = out_done_reg;

endmodule

// ===== rtl/perceptron_train_classify.sv =====
// Non-last feature beat: accepted in ST_IDLE, then weight read and multiply in ST_MUL.
// Last beat: ST_MUL, ST_ACC, ST_SCORE, ST_DECIDE loads the result; input reopens then.
// Miss in learn mode: ST_WALK then ST_DRAIN walk the weights of the sample's features,
//   one read-modify-write per cycle on the weight memory.
// Reset: a clearing pass zeroes all 1024 weight entries; input not ready meanwhile.
// Registers reset to learn_enable=1, train_count=1; bias, streak, converged cleared.
module perceptron_train_classify (
    input  logic                               clk,
    input  logic                               rst_n,
    ptc_in_if.sink                             in_ch,
    ptc_out_if.source                          out_ch,
    input  logic                               cfg_we,
    input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ptc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    ptc_pkg::ptc_cmd_t    cmd;
    ptc_pkg::ptc_status_t status;

    ptc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .cmd    (cmd)
    );

    ptc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    a_no_accept_while_clearing: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.clear |-> !in_ch.ready
    ) else $error("input ready during weight clearing pass");

    a_no_accept_while_walking: assert property (
        @(posedge clk) disable iff (!rst_n) cmd.walk_rd |-> !in_ch.ready
    ) else $error("input ready during weight update walk");

    a_result_from_decide: assert property (
        @(posedge clk) disable iff (!rst_n) $rose(out_ch.valid) |-> $past(cmd.out_load)
    ) else $error("result beat appeared without a decision");

    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_ch.valid || out_ch.ready)
    ) else $error("pending result overwritten");

endmodule

// ===== dv/perceptron_train_classify_tb.sv =====
module perceptron_train_classify_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_FEATURES = ptc_pkg::MAX_FEATURES;
    localparam int WEIGHT_BITS  = ptc_pkg::WEIGHT_BITS;
    localparam int FEAT_W       = ptc_pkg::FEAT_W;
    localparam int ACC_W        = ptc_pkg::ACC_W;
    localparam int STREAK_W     = ptc_pkg::STREAK_W;
    localparam int CFG_IDX_W    = ptc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W   = ptc_pkg::CFG_DATA_W;
    localparam logic [CFG_IDX_W-1:0] CFG_LEARN_ENABLE = ptc_pkg::CFG_LEARN_ENABLE;
    localparam logic [CFG_IDX_W-1:0] CFG_TRAIN_COUNT  = ptc_pkg::CFG_TRAIN_COUNT;

    typedef struct packed {
        logic signed [ACC_W-1:0]  score;
        logic                     correct;
        logic                     updated;
        logic [STREAK_W-1:0]      streak;
        logic                     converged;
    } sample_verdict_t;

    logic clk = 1'b0;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ptc_in_if  in_ch ();
    ptc_out_if out_ch ();

    perceptron_train_classify uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Predictor state
    logic signed [WEIGHT_BITS-1:0] w_mem [MAX_FEATURES];
    logic [FEAT_W-1:0]             feat_buf [MAX_FEATURES];
    logic signed [WEIGHT_BITS-1:0] bias_w;
    int                            feat_pos;
    logic signed [ACC_W-1:0]       run_sum;
    logic [STREAK_W-1:0]           streak_cnt;
    logic                          conv;
    logic                          learn_en;
    logic [STREAK_W-1:0]           goal_count;

    sample_verdict_t verdicts_due[$];
    logic [FEAT_W-1:0] pix_q[$];

    bit no_gaps = 1'b0;
    int sink_wait = 0;
    int bad_results = 0;
    int results_checked = 0;
    int items_sent = 0;
    int samples_sent = 0;
    int update_count = 0;
    int predict_count = 0;

    function automatic longint clamp(input longint v, input int bits);
        longint hi;
        hi = (longint'(1) << (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Folds one accepted feature beat into the predictor; queues a verdict on the last one.
    function automatic void absorb_feature(input logic [FEAT_W-1:0] f, input logic lab,
                                           input logic last);
        longint s;
        longint sgn;
        bit hit;
        sample_verdict_t v;
        if (feat_pos < MAX_FEATURES)
        begin
            feat_buf[feat_pos] = f;
            run_sum = ACC_W'(clamp(longint'(run_sum)
                                   + longint'(w_mem[feat_pos]) * longint'(f), ACC_W));
            feat_pos++;
        end
        if (!last)
            return;
        s = clamp(longint'(run_sum) + longint'(bias_w), ACC_W);
        if (learn_en)
            hit = lab ? (s > 0) : (s < 0);
        else
            hit = lab ? (s >= 0) : (s <= 0);
        v.updated = 1'b0;
        if (learn_en && !conv)
        begin
            if (hit)
            begin
                if (streak_cnt != '1)
                    streak_cnt++;
            end
            else
            begin
                sgn = lab ? 1 : -1;
                streak_cnt = '0;
                bias_w = WEIGHT_BITS'(clamp(longint'(bias_w) + sgn, WEIGHT_BITS));
                for (int i = 0; i < feat_pos; i++)
                    w_mem[i] = WEIGHT_BITS'(clamp(longint'(w_mem[i])
                                                  + sgn * longint'(feat_buf[i]), WEIGHT_BITS));
                v.updated = 1'b1;
                update_count++;
            end
            if (streak_cnt >= goal_count)
                conv = 1'b1;
        end
        if (!learn_en)
            predict_count++;
        v.score = s[ACC_W-1:0];
        v.correct = hit;
        v.streak = streak_cnt;
        v.converged = conv;
        verdicts_due = {verdicts_due, v};
        samples_sent++;
        feat_pos = 0;
        run_sum = '0;
    endfunction

    task automatic send_feature(input logic [FEAT_W-1:0] f, input logic lab, input logic last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        repeat (gap)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.feature <= f;
        in_ch.label <= lab;
        in_ch.last_feature <= last;
        @(posedge clk);
        while (in_ch.ready !== 1'b1)
            @(posedge clk);
        absorb_feature(f, lab, last);
        items_sent++;
    endtask

    // Sends pix_q as one sample; scramble puts random labels on all but the last beat.
    task automatic send_sample(input logic lab, input bit scramble);
        int n;
        n = pix_q.size();
        for (int k = 0; k < n; k++)
            send_feature(pix_q[k], (scramble && k != n - 1) ? 1'($urandom_range(0, 1)) : lab,
                         k == n - 1);
    endtask

    task automatic fill_random(input int len);
        pix_q.delete();
        repeat (len)
            pix_q = {pix_q, FEAT_W'($urandom)};
    endtask

    // Linearly separable data: class 1 when the first pair outweighs the second.
    task automatic teacher_sample();
        logic [FEAT_W-1:0] a, b, c, d;
        a = FEAT_W'($urandom);
        b = FEAT_W'($urandom);
        c = FEAT_W'($urandom);
        d = FEAT_W'($urandom);
        pix_q = '{a, b, c, d};
        send_sample((int'(a) + int'(b)) > (int'(c) + int'(d)), 1'b0);
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    // A miss walks up to the whole weight store after its result beat.
    task automatic settle();
        drain_results();
        repeat (MAX_FEATURES + 16)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_LEARN_ENABLE)
            learn_en = val[0];
        else if (idx == CFG_TRAIN_COUNT)
            goal_count = val[STREAK_W-1:0];
    endtask

    // Runs under reset register values; zero weights make it a miss that walks every entry.
    task automatic test_overlong_sample();
        fill_random(MAX_FEATURES + 6);
        pix_q[0] = 8'hFF;
        pix_q[1] = 8'h00;
        send_sample(1'b1, 1'b1);
    endtask

    // Single zero features expose the bias alone, including a zero score in learn mode.
    task automatic test_zero_score_learn();
        settle();
        write_reg(CFG_TRAIN_COUNT, 16'hFFFF);
        pix_q = '{8'd0};
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
    endtask

    task automatic test_predict_mode();
        settle();
        write_reg(CFG_LEARN_ENABLE, 16'd0);
        write_reg(CFG_TRAIN_COUNT, 16'd1);
        pix_q = '{8'd0};
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b0);
        pix_q = '{8'hFF};
        send_sample(1'b1, 1'b0);
        pix_q = '{8'hFF, 8'h00};
        send_sample(1'b0, 1'b0);
        settle();
        write_reg(CFG_TRAIN_COUNT, 16'd0);
        pix_q = '{8'd1, 8'd2};
        send_sample(1'b1, 1'b0);
    endtask

    task automatic test_field_extremes();
        settle();
        write_reg(CFG_LEARN_ENABLE, 16'd1);
        write_reg(CFG_TRAIN_COUNT, 16'hFFFF);
        pix_q = '{8'hFF};
        send_sample(1'b1, 1'b0);
        pix_q = '{8'hFF, 8'hFF};
        send_sample(1'b0, 1'b0);
        pix_q = '{8'h00, 8'h80, 8'hFF, 8'h01};
        send_sample(1'b1, 1'b1);
        pix_q = '{8'h55, 8'hAA};
        send_sample(1'b0, 1'b0);
    endtask

    task automatic test_random_traffic(input int budget);
        int start;
        int nsamp;
        int pick;
        for (int phase = 0; phase < 4; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    write_reg(CFG_LEARN_ENABLE, 16'd1);
                    write_reg(CFG_TRAIN_COUNT, 16'hFFFF);
                end
                1:
                begin
                    write_reg(CFG_LEARN_ENABLE, 16'd0);
                    write_reg(CFG_TRAIN_COUNT, CFG_DATA_W'($urandom));
                end
                2:
                begin
                    write_reg(CFG_LEARN_ENABLE, 16'd1);
                    write_reg(CFG_TRAIN_COUNT, CFG_DATA_W'($urandom_range(40000, 65535)));
                end
                default:
                    write_reg(CFG_TRAIN_COUNT, 16'hFFFF);
            endcase
            start = items_sent;
            nsamp = 0;
            while (items_sent - start < budget / 4)
            begin
                if (nsamp % 20 == 0)
                    no_gaps = ($urandom_range(0, 4) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    teacher_sample();
                end
                else
                begin
                    fill_random(($urandom_range(0, 9) == 0) ? $urandom_range(9, 80)
                                                            : $urandom_range(1, 8));
                    send_sample(1'($urandom_range(0, 1)), pick >= 90);
                end
                nsamp++;
                if ($urandom_range(0, 39) == 0)
                    drain_results();
            end
        end
        no_gaps = 1'b0;
    endtask

    // Build a streak, then drop the goal to zero so the next learn-mode sample freezes
    // the block; after that nothing may move in either mode.
    task automatic test_convergence();
        int tries;
        settle();
        write_reg(CFG_LEARN_ENABLE, 16'd1);
        write_reg(CFG_TRAIN_COUNT, 16'hFFFF);
        tries = 0;
        while (streak_cnt < 3 && tries < 300)
        begin
            teacher_sample();
            tries++;
        end
        settle();
        write_reg(CFG_TRAIN_COUNT, 16'd0);
        repeat (6)
            teacher_sample();
        fill_random(5);
        send_sample(1'b0, 1'b0);
        settle();
        write_reg(CFG_LEARN_ENABLE, 16'd0);
        repeat (4)
            teacher_sample();
    endtask

    always @(negedge clk)
    begin
        if (rst_n !== 1'b1)
        begin
            out_ch.ready <= 1'b0;
        end
        else if (sink_wait > 0)
        begin
            out_ch.ready <= 1'b0;
            sink_wait = sink_wait - 1;
        end
        else
        begin
            out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : result_check
        sample_verdict_t want;
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        begin
            results_checked++;
            sink_wait = no_gaps ? 0 : $urandom_range(0, 14);
            if (verdicts_due.size() == 0)
            begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result beat: score %0d streak %0d",
                             out_ch.score, out_ch.streak);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (out_ch.score !== want.score || out_ch.correct !== want.correct
                    || out_ch.weights_updated !== want.updated
                    || out_ch.streak !== want.streak || out_ch.converged !== want.converged)
                begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display({"result %0d mismatch: expected score %0d correct %0b ",
                                  "updated %0b streak %0d converged %0b, got score %0d ",
                                  "correct %0b updated %0b streak %0d converged %0b"},
                                 results_checked, want.score, want.correct, want.updated,
                                 want.streak, want.converged, out_ch.score, out_ch.correct,
                                 out_ch.weights_updated, out_ch.streak, out_ch.converged);
                end
            end
        end
    end

    initial
    begin
        #10ms;
        $display("perceptron_train_classify_tb: FAIL");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.feature = '0;
        in_ch.label = 1'b0;
        in_ch.last_feature = 1'b0;
        out_ch.ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_LEARN_ENABLE;
        cfg_data = '0;
        foreach (w_mem[i])
        begin
            w_mem[i] = '0;
            feat_buf[i] = '0;
        end
        bias_w = '0;
        feat_pos = 0;
        run_sum = '0;
        streak_cnt = '0;
        conv = 1'b0;
        learn_en = 1'b1;
        goal_count = 16'd1;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_overlong_sample();
        test_zero_score_learn();
        test_predict_mode();
        test_field_extremes();
        test_random_traffic(100);
        test_convergence();
        settle();

        $display("run covered %0d feature beats in %0d samples, %0d weight updates, %0d predict-only",
                 items_sent, samples_sent, update_count, predict_count);
        $display("checked %0d result beats; final streak %0d, converged %0b, %0d failures",
                 results_checked, streak_cnt, conv, bad_results);
        if (bad_results == 0 && verdicts_due.size() == 0)
            $display("perceptron_train_classify_tb: PASS");
        else
            $display("perceptron_train_classify_tb: FAIL");
        $finish;
    end
endmodule
